[design/cte_pkg.sv]
// Shared types, operation codes and constants of the text console engine.
package cte_pkg;

    localparam int CTE_COLS = 80;
    localparam int CTE_ROWS = 25;

    localparam int OFF_W = 12;

    localparam logic [2:0] FN_PRINT     = 3'd0;
    localparam logic [2:0] FN_CLEAR     = 3'd1;
    localparam logic [2:0] FN_SET_CUR   = 3'd2;
    localparam logic [2:0] FN_WRITE     = 3'd3;
    localparam logic [2:0] FN_CLEAR_ROW = 3'd4;
    localparam logic [2:0] FN_READ      = 3'd5;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LAST  = 8'h7F;

    localparam logic [7:0] TAB_STEP = 8'd8;

    localparam logic [7:0] BLANK_ATTR_RST = 8'h0F;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ch;
        logic [7:0] color;
        logic [6:0] col;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic [15:0] cell_value;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic at_last;
    } t_sweep_sts;

endpackage

[design/cte_cell_mem.sv]
// Cell store: one write port and one registered read port.
module cte_cell_mem
    import cte_pkg::*;
#(
    parameter int DEPTH = CTE_COLS * CTE_ROWS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[design/cte_addr_unit.sv]
// Shared address unit that maps a row and column to a linear cell offset.
module cte_addr_unit
    import cte_pkg::*;
#(
    parameter int COLS = CTE_COLS
) (
    input  logic [4:0]       i_row,
    input  logic [6:0]       i_col,
    output logic [OFF_W-1:0] o_off
);

    assign o_off = OFF_W'(i_row) * OFF_W'(COLS) + OFF_W'(i_col);

endmodule

[design/cte_sweep_unit.sv]
// Address sweep counter that walks a range of cells one per cycle.
module cte_sweep_unit
    import cte_pkg::*;
#(
    parameter int AW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_first,
    input  logic [AW-1:0] i_last,
    output logic [AW-1:0] o_addr,
    output t_sweep_sts    o_sts
);

    logic          r_busy;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last;
    logic          at_last;

    assign at_last = r_busy && (r_addr == r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (at_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_addr <= i_first;
            r_last <= i_last;
        end else if (r_busy) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    assign o_addr        = r_addr;
    assign o_sts.busy    = r_busy;
    assign o_sts.at_last = at_last;

endmodule

[design/text_console_engine_core.sv]
// Top level of the text console engine: sequencer, cursor and result register.
//
// Usage: an operation beat enters on the in channel (valid/ready), a result beat
// leaves on the out channel (valid/ready), and the attribute of blank cells is
// written on the cfg channel, which is always ready and should be used only
// while the engine is idle. The engine takes one operation at a time and
// drops in_ready from the accepting edge until its result is in the output
// register.
// A read passes through an extra read state, and a row clear or a screen clear
// sweeps its cells before the result. A print that scrolls also moves the screen
// up one row: the cell store, which has one write port, copies one cell per
// cycle and then fills the bottom row. The engine passes through its idle state
// before it takes the next operation.
// After reset the engine sweeps the store once with blank cells; in_ready stays
// low meanwhile and cfg writes are taken.
// When the receiver stalls the result waits in the output register; the next
// operation is accepted and runs, and it holds its own result until the
// register is free.
module text_console_engine_core
    import cte_pkg::*;
#(
    parameter int COLS = CTE_COLS,
    parameter int ROWS = CTE_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [AW-1:0] COLS_A      = AW'(COLS);
    localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST_A = AW'(CELLS - COLS - 1);
    localparam logic [AW-1:0] FILL_BASE_A = AW'(CELLS - COLS);

    typedef enum logic [9:0] {
        S_BOOT  = 10'b00_0000_0001,
        S_INIT  = 10'b00_0000_0010,
        S_IDLE  = 10'b00_0000_0100,
        S_EXEC  = 10'b00_0000_1000,
        S_READ  = 10'b00_0001_0000,
        S_COPY  = 10'b00_0010_0000,
        S_DRAIN = 10'b00_0100_0000,
        S_FILL  = 10'b00_1000_0000,
        S_CLEAR = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    t_in_item   r_in;
    logic [6:0] r_col, n_col;
    logic [4:0] r_row, n_row;
    logic [7:0] r_blank;
    logic [15:0] r_fill_val, n_fill_val;
    logic [15:0] r_cell, n_cell;
    logic       r_pend;
    logic [AW-1:0] r_pend_addr;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [4:0]       au_row;
    logic [6:0]       au_col;
    logic [OFF_W-1:0] au_off;

    logic          sw_start;
    logic [AW-1:0] sw_first, sw_last, sw_addr;
    t_sweep_sts    sw_sts;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    logic [7:0] pc_col;
    logic [5:0] pc_row;
    logic       in_range;
    logic       printable;

    cte_addr_unit #(.COLS(COLS)) u_addr (
        .i_row (au_row),
        .i_col (au_col),
        .o_off (au_off)
    );

    cte_sweep_unit #(.AW(AW)) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sw_start),
        .i_first (sw_first),
        .i_last  (sw_last),
        .o_addr  (sw_addr),
        .o_sts   (sw_sts)
    );

    cte_cell_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_range  = (7'(r_in.col) < 7'(COLS - 1) + 7'd1 || COLS == 128)
                       && (r_in.col <= 7'(COLS - 1))
                       && (r_in.row <= 5'(ROWS - 1));
    assign printable = (r_in.ch >= CH_SPACE) && (r_in.ch <= CH_LAST);

    always_comb begin
        if (r_state == S_EXEC && r_in.func == FN_PRINT) begin
            au_row = r_row;
            au_col = (r_in.ch == CH_BS) ? r_col - 7'd1 : r_col;
        end else if (r_state == S_EXEC) begin
            au_row = r_in.row;
            au_col = (r_in.func == FN_CLEAR_ROW) ? 7'd0 : r_in.col;
        end else begin
            au_row = r_row;
            au_col = r_col;
        end
    end

    always_comb begin
        pc_col = {1'b0, r_col};
        pc_row = {1'b0, r_row};
        priority if (r_in.ch == CH_LF) begin
            pc_col = 8'd0;
            pc_row = pc_row + 6'd1;
        end else if (r_in.ch == CH_CR) begin
            pc_col = 8'd0;
        end else if (r_in.ch == CH_TAB) begin
            pc_col = (pc_col + TAB_STEP) & ~(TAB_STEP - 8'd1);
        end else if (r_in.ch == CH_BS) begin
            if (r_col != 7'd0) begin
                pc_col = pc_col - 8'd1;
            end
        end else if (printable) begin
            pc_col = pc_col + 8'd1;
        end else begin
            pc_col = {1'b0, r_col};
        end
        if (pc_col >= 8'(COLS)) begin
            pc_col = 8'd0;
            pc_row = pc_row + 6'd1;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_fill_val = r_fill_val;
        n_cell     = r_cell;
        sw_start   = 1'b0;
        sw_first   = '0;
        sw_last    = LAST_A;
        mem_we     = 1'b0;
        mem_waddr  = r_pend_addr;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = sw_addr + COLS_A;
        unique case (r_state)
            S_BOOT: begin
                sw_start = 1'b1;
                n_state  = S_INIT;
            end
            S_INIT, S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = sw_addr;
                mem_wdata = r_fill_val;
                if (sw_sts.at_last) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cell  = '0;
                n_state = S_DONE;
                unique case (r_in.func)
                    FN_PRINT: begin
                        mem_waddr = au_off[AW-1:0];
                        if (r_in.ch == CH_BS) begin
                            mem_we    = (r_col != 7'd0);
                            mem_wdata = {r_in.color, CH_SPACE};
                        end else begin
                            mem_we    = printable;
                            mem_wdata = {r_in.color, r_in.ch};
                        end
                        n_col = pc_col[6:0];
                        if (pc_row >= 6'(ROWS)) begin
                            n_row      = 5'(ROWS - 1);
                            n_fill_val = {r_blank, CH_SPACE};
                            sw_start   = 1'b1;
                            sw_last    = COPY_LAST_A;
                            n_state    = S_COPY;
                        end else begin
                            n_row = pc_row[4:0];
                        end
                    end
                    FN_CLEAR: begin
                        n_col      = 7'd0;
                        n_row      = 5'd0;
                        n_fill_val = {r_blank, CH_SPACE};
                        sw_start   = 1'b1;
                        n_state    = S_CLEAR;
                    end
                    FN_SET_CUR: begin
                        n_col = (r_in.col > 7'(COLS - 1)) ? 7'(COLS - 1) : r_in.col;
                        n_row = (r_in.row > 5'(ROWS - 1)) ? 5'(ROWS - 1) : r_in.row;
                    end
                    FN_WRITE: begin
                        mem_we    = in_range;
                        mem_waddr = au_off[AW-1:0];
                        mem_wdata = {r_in.color, r_in.ch};
                    end
                    FN_CLEAR_ROW: begin
                        if (r_in.row <= 5'(ROWS - 1)) begin
                            n_fill_val = {r_blank, CH_SPACE};
                            sw_start   = 1'b1;
                            sw_first   = au_off[AW-1:0];
                            sw_last    = au_off[AW-1:0] + COLS_A - AW'(1);
                            n_state    = S_FILL;
                        end
                    end
                    FN_READ: begin
                        if (in_range) begin
                            mem_re    = 1'b1;
                            mem_raddr = au_off[AW-1:0];
                            n_state   = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_cell  = mem_rdata;
                n_state = S_DONE;
            end
            S_COPY: begin
                mem_re = 1'b1;
                mem_we = r_pend;
                if (sw_sts.at_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                mem_we   = 1'b1;
                sw_start = 1'b1;
                sw_first = FILL_BASE_A;
                n_state  = S_FILL;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = sw_addr;
                mem_wdata = r_fill_val;
                if (sw_sts.at_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_BOOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_col       <= 7'd0;
            r_row       <= 5'd0;
            r_blank     <= BLANK_ATTR_RST;
            r_fill_val  <= {BLANK_ATTR_RST, CH_SPACE};
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_fill_val <= n_fill_val;
            r_pend     <= (r_state == S_COPY);
            if (i_cfg_valid) begin
                r_blank <= i_cfg_data;
            end
            if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell      <= n_cell;
        r_pend_addr <= sw_addr;
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out.cursor_col    <= r_col;
            r_out.cursor_row    <= r_row;
            r_out.cursor_offset <= au_off[10:0];
            r_out.cell_value    <= r_cell;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Engine stayed ready after taking an operation.");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= 7'(COLS - 1)) && (r_row <= 5'(ROWS - 1)))
        else $error("Cursor left the screen.");

    a_pend_from_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(r_state == S_COPY))
        else $error("Copy write pending outside a scroll.");

    a_sweep_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sw_sts.busy |-> (r_state == S_INIT || r_state == S_CLEAR
                         || r_state == S_COPY || r_state == S_FILL))
        else $error("Sweep counter running in a state that does not use it.");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench of the text console engine with directed and random operations.
`timescale 1ns / 100ps

module tb;
    import cte_pkg::*;

    localparam logic [2:0] FN_NOP6 = 3'd6;
    localparam logic [2:0] FN_NOP7 = 3'd7;
    localparam int CELLS = CTE_COLS * CTE_ROWS;
    localparam int LONG_HOLD = 300;
    localparam int TIMEOUT_NS = 30_000_000;

    typedef struct {
        t_in_item  op;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    logic [15:0] screen_mem [CELLS];
    int          pcol;
    int          prow;
    logic [7:0]  blank_attr;

    t_out_item   expected_status_q [$];
    t_stim_row   stim_table [$];

    bit idle_enable = 1'b1;
    bit hold_request = 1'b0;
    int stall_left = 0;
    int err_count = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int reads_sent = 0;
    int attr_writes = 0;
    int scroll_count = 0;
    int clear_count = 0;

    text_console_engine_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [15:0] blank_word();
        return {blank_attr, CH_SPACE};
    endfunction

    function automatic void put_word(int c, int r, logic [15:0] w);
        if (c < CTE_COLS && r < CTE_ROWS) begin
            screen_mem[r * CTE_COLS + c] = w;
        end
    endfunction

    function automatic t_out_item console_apply(t_in_item op);
        t_out_item   res;
        logic [15:0] rd_word;
        int          c;
        int          r;
        int          i;
        rd_word = '0;
        c = int'(op.col);
        r = int'(op.row);
        case (op.func)
            FN_PRINT: begin
                if (op.ch == CH_LF) begin
                    pcol = 0;
                    prow++;
                end else if (op.ch == CH_CR) begin
                    pcol = 0;
                end else if (op.ch == CH_TAB) begin
                    pcol = (pcol + int'(TAB_STEP)) & ~(int'(TAB_STEP) - 1);
                end else if (op.ch == CH_BS) begin
                    if (pcol > 0) begin
                        pcol--;
                        put_word(pcol, prow, {op.color, CH_SPACE});
                    end
                end else if (op.ch >= CH_SPACE && op.ch <= CH_LAST) begin
                    put_word(pcol, prow, {op.color, op.ch});
                    pcol++;
                end
                if (pcol >= CTE_COLS) begin
                    pcol = 0;
                    prow++;
                end
                if (prow >= CTE_ROWS) begin
                    for (i = 0; i < CTE_COLS * (CTE_ROWS - 1); i++) begin
                        screen_mem[i] = screen_mem[i + CTE_COLS];
                    end
                    for (i = 0; i < CTE_COLS; i++) begin
                        put_word(i, CTE_ROWS - 1, blank_word());
                    end
                    prow = CTE_ROWS - 1;
                    scroll_count++;
                end
            end
            FN_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    screen_mem[i] = blank_word();
                end
                pcol = 0;
                prow = 0;
                clear_count++;
            end
            FN_SET_CUR: begin
                pcol = (c >= CTE_COLS) ? CTE_COLS - 1 : c;
                prow = (r >= CTE_ROWS) ? CTE_ROWS - 1 : r;
            end
            FN_WRITE: begin
                put_word(c, r, {op.color, op.ch});
            end
            FN_CLEAR_ROW: begin
                if (r < CTE_ROWS) begin
                    for (i = 0; i < CTE_COLS; i++) begin
                        put_word(i, r, blank_word());
                    end
                end
            end
            FN_READ: begin
                if (c < CTE_COLS && r < CTE_ROWS) begin
                    rd_word = screen_mem[r * CTE_COLS + c];
                end
            end
            default: begin
            end
        endcase
        res.cursor_col = 7'(pcol);
        res.cursor_row = 5'(prow);
        res.cursor_offset = 11'(prow * CTE_COLS + pcol);
        res.cell_value = rd_word;
        return res;
    endfunction

    function automatic t_in_item mk_op(logic [2:0] f, logic [7:0] ch, logic [7:0] color,
                                       logic [6:0] col, logic [4:0] row);
        t_in_item op;
        op.func = f;
        op.ch = ch;
        op.color = color;
        op.col = col;
        op.row = row;
        return op;
    endfunction

    function automatic t_out_item mk_res(int col, int row, int off, logic [15:0] word);
        t_out_item res;
        res.cursor_col = 7'(col);
        res.cursor_row = 5'(row);
        res.cursor_offset = 11'(off);
        res.cell_value = word;
        return res;
    endfunction

    function automatic void add_row(t_in_item op, bit typed, t_out_item want);
        t_stim_row row;
        row.op = op;
        row.typed = typed;
        row.want = want;
        stim_table.push_back(row);
    endfunction

    function automatic t_in_item random_op();
        t_in_item op;
        int       sel;
        int       pick;
        op = 31'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            op.func = FN_PRINT;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                op.ch = 8'($urandom_range(32, 127));
            end else if (pick < 73) begin
                op.ch = CH_LF;
            end else if (pick < 76) begin
                op.ch = CH_CR;
            end else if (pick < 81) begin
                op.ch = CH_TAB;
            end else if (pick < 87) begin
                op.ch = CH_BS;
            end
        end else if (sel < 67) begin
            op.func = FN_SET_CUR;
        end else if (sel < 75) begin
            op.func = FN_WRITE;
        end else if (sel < 78) begin
            op.func = FN_CLEAR_ROW;
        end else if (sel < 79) begin
            op.func = FN_CLEAR;
        end else if (sel < 96) begin
            op.func = FN_READ;
            if ($urandom_range(0, 1) == 1) begin
                op.row = 5'((prow > 0) ? prow - int'($urandom_range(0, 1)) : prow);
                op.col = 7'($urandom_range(0, CTE_COLS - 1));
            end
        end else begin
            op.func = ($urandom_range(0, 1) == 1) ? FN_NOP6 : FN_NOP7;
        end
        return op;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s mismatch in result beat %0d: got %0d, expected %0d",
                                      name, results_seen, got, want));
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_status_q.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: %h", got));
        end else begin
            want = expected_status_q.pop_front();
            compare_field("cursor_col", got.cursor_col, want.cursor_col);
            compare_field("cursor_row", got.cursor_row, want.cursor_row);
            compare_field("cursor_offset", got.cursor_offset, want.cursor_offset);
            compare_field("cell_value", got.cell_value, want.cell_value);
        end
        results_seen++;
    endtask

    task automatic send_op(t_in_item op, bit typed, t_out_item want);
        t_out_item pred;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= op;
        do @(posedge clk); while (!in_ready);
        pred = console_apply(op);
        expected_status_q.push_back(typed ? want : pred);
        ops_sent++;
        if (op.func == FN_READ) begin
            reads_sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_blank_attr(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        blank_attr = value;
        attr_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(int count, logic [7:0] attr, bit idle, bit long_hold);
        t_in_item op;
        drain_results();
        write_blank_attr(attr);
        idle_enable = idle;
        if (long_hold) begin
            hold_request = 1'b1;
        end
        repeat (count) begin
            op = random_op();
            send_op(op, 1'b0, '0);
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n) begin
                if (out_valid && out_ready) begin
                    check_result(out_data);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= (stall_left == 0);
                end else if (hold_request) begin
                    hold_request = 1'b0;
                    stall_left = LONG_HOLD;
                    out_ready <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 4);
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int k;
        blank_attr = BLANK_ATTR_RST;
        for (k = 0; k < CELLS; k++) begin
            screen_mem[k] = {BLANK_ATTR_RST, CH_SPACE};
        end
        pcol = 0;
        prow = 0;

        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0), 1'b1,
                mk_res(0, 0, 0, {BLANK_ATTR_RST, CH_SPACE}));
        add_row(mk_op(FN_READ, 8'hFF, 8'hFF, 7'd127, 5'd31), 1'b1, mk_res(0, 0, 0, 16'h0000));
        add_row(mk_op(FN_PRINT, 8'h41, 8'h1E, 7'd0, 5'd0), 1'b1, mk_res(1, 0, 1, 16'h0000));
        add_row(mk_op(FN_PRINT, CH_LAST, 8'hFF, 7'd0, 5'd0), 1'b1, mk_res(2, 0, 2, 16'h0000));
        add_row(mk_op(FN_PRINT, 8'h80, 8'h55, 7'd0, 5'd0), 1'b1, mk_res(2, 0, 2, 16'h0000));
        add_row(mk_op(FN_PRINT, 8'hFF, 8'h55, 7'd0, 5'd0), 1'b1, mk_res(2, 0, 2, 16'h0000));
        add_row(mk_op(FN_PRINT, 8'h1F, 8'h55, 7'd0, 5'd0), 1'b1, mk_res(2, 0, 2, 16'h0000));
        add_row(mk_op(FN_PRINT, CH_TAB, 8'h00, 7'd0, 5'd0), 1'b1, mk_res(8, 0, 8, 16'h0000));
        add_row(mk_op(FN_PRINT, CH_BS, 8'h4C, 7'd0, 5'd0), 1'b1, mk_res(7, 0, 7, 16'h0000));
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd7, 5'd0), 1'b1,
                mk_res(7, 0, 7, {8'h4C, CH_SPACE}));
        add_row(mk_op(FN_PRINT, CH_CR, 8'h00, 7'd0, 5'd0), 1'b1, mk_res(0, 0, 0, 16'h0000));
        add_row(mk_op(FN_PRINT, CH_BS, 8'h33, 7'd0, 5'd0), 1'b1, mk_res(0, 0, 0, 16'h0000));
        add_row(mk_op(FN_PRINT, CH_LF, 8'h00, 7'd0, 5'd0), 1'b1, mk_res(0, 1, 80, 16'h0000));
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd1, 5'd0), 1'b1, mk_res(0, 1, 80, 16'hFF7F));
        add_row(mk_op(FN_SET_CUR, 8'h00, 8'h00, 7'd127, 5'd31), 1'b1,
                mk_res(79, 24, 1999, 16'h0000));
        add_row(mk_op(FN_PRINT, 8'h5A, 8'h21, 7'd0, 5'd0), 1'b1, mk_res(0, 24, 1920, 16'h0000));
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd79, 5'd23), 1'b1,
                mk_res(0, 24, 1920, 16'h215A));
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd24), 1'b0, '0);
        add_row(mk_op(FN_WRITE, 8'hFF, 8'hAA, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_WRITE, 8'h42, 8'h77, 7'd80, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_WRITE, 8'h43, 8'h77, 7'd0, 5'd25), 1'b0, '0);
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_CLEAR_ROW, 8'h00, 8'h00, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_CLEAR_ROW, 8'h00, 8'h00, 7'd0, 5'd31), 1'b0, '0);
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_NOP6, 8'hFF, 8'hFF, 7'd127, 5'd31), 1'b0, '0);
        add_row(mk_op(FN_NOP7, 8'h00, 8'h00, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_SET_CUR, 8'h00, 8'h00, 7'd72, 5'd24), 1'b0, '0);
        add_row(mk_op(FN_PRINT, CH_TAB, 8'h00, 7'd0, 5'd0), 1'b0, '0);
        add_row(mk_op(FN_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0), 1'b1, mk_res(0, 0, 0, 16'h0000));
        add_row(mk_op(FN_READ, 8'h00, 8'h00, 7'd5, 5'd5), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        do @(posedge clk); while (!(rst_n && in_ready));
        write_blank_attr(8'h00);

        foreach (stim_table[idx]) begin
            send_op(stim_table[idx].op, stim_table[idx].typed, stim_table[idx].want);
        end

        run_random_phase(250, 8'hFF, 1'b1, 1'b1);
        run_random_phase(250, 8'($urandom), 1'b1, 1'b0);
        run_random_phase(250, BLANK_ATTR_RST, 1'b1, 1'b0);
        run_random_phase(250, 8'($urandom), 1'b1, 1'b1);
        run_random_phase(150, 8'($urandom), 1'b0, 1'b0);

        drain_results();
        repeat (CELLS + 16) @(posedge clk);

        $display("Ran %0d operations and checked %0d result beats, %0d of them cell reads.",
                 ops_sent, results_seen, reads_sent);
        $display("Blank attribute took %0d settings; the model saw %0d scrolls, %0d clears.",
                 attr_writes, scroll_count, clear_count);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[text_console_engine_core.f]
design/cte_pkg.sv
design/cte_cell_mem.sv
design/cte_addr_unit.sv
design/cte_sweep_unit.sv
design/text_console_engine_core.sv
tb/sv/tb.sv
